@@ rtl/core/density_grid_splat_accumulator_defines.svh @@
`ifndef DENSITY_GRID_SPLAT_ACCUMULATOR_DEFINES_SVH
`define DENSITY_GRID_SPLAT_ACCUMULATOR_DEFINES_SVH

// Checks a condition in the same cycle as its trigger; reset masks the check.
`define DGSA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dgsa same-cycle check failed");

// Checks a condition in the cycle after its trigger; reset masks the check.
`define DGSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dgsa next-cycle check failed");

`endif

@@ rtl/core/dgsa_pkg.sv @@
`timescale 1ns / 1ps
package dgsa_pkg;

  localparam int GRID_SIDE_DEFAULT     = 256;
  localparam int KERNEL_RADIUS_DEFAULT = 10;
  localparam int POS_FRAC_BITS_DEFAULT = 8;

  localparam int CELL_DATA_W = 32;
  localparam int POS_W       = 24;
  localparam int OFFSET_W    = 23;
  localparam int SHIFT_W     = 4;
  localparam int MARGIN_W    = 7;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 23;
  localparam int DENSITY_W   = 64;

  typedef logic [1:0] cmd_code_t;
  localparam cmd_code_t CMD_ADD   = 2'd0;
  localparam cmd_code_t CMD_SUB   = 2'd1;
  localparam cmd_code_t CMD_QUERY = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_EDGE = 2'd1;
  localparam status_t ST_SKIP = 2'd2;
  localparam status_t ST_SAT  = 2'd3;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  localparam cfg_index_t REG_ORIGIN_OFFSET = 2'd0;
  localparam cfg_index_t REG_CELL_SHIFT    = 2'd1;
  localparam cfg_index_t REG_EDGE_MARGIN   = 2'd2;

  localparam logic [OFFSET_W-1:0] ORIGIN_OFFSET_RESET = 23'd131200;
  localparam logic [SHIFT_W-1:0]  CELL_SHIFT_RESET    = 4'd2;
  localparam logic [MARGIN_W-1:0] EDGE_MARGIN_RESET   = 7'd10;

  typedef struct packed {
    cmd_code_t               command;
    logic signed [POS_W-1:0] x_position;
    logic signed [POS_W-1:0] y_position;
  } cmd_word_t;

  typedef struct packed {
    logic [DENSITY_W-1:0] density_squared;
    status_t              status;
  } res_word_t;

  typedef struct packed {
    logic clear_step;
    logic load_in;
    logic map;
    logic check;
    logic step;
    logic sq_load;
    logic load_out;
  } dp_ctrl_t;

  typedef struct packed {
    cmd_code_t command;
    logic      clear_last;
    logic      skip;
    logic      at_edge;
    logic      last;
  } dp_stat_t;

endpackage

@@ rtl/core/density_grid_splat_accumulator.sv @@
// Update (add or subtract): a one-cell-per-cycle read-modify-write walk through the cell RAM over
// the kernel window; an update whose window would leave the grid is skipped.
// Query: a RAM read of the cell, then one 32x32 squaring stage; a cell in the edge margin is not read.
// One word is worked at a time; the next word is taken the cycle after a result is registered.
// Reset (rst, synchronous) restores the register defaults, then zeroes the cell RAM one entry
// per cycle over all GRID_SIDE*GRID_SIDE entries (65536 at default) with cmd_ready held low.
`timescale 1ns / 1ps
module density_grid_splat_accumulator
  import dgsa_pkg::*;
#(
  parameter int GRID_SIDE              = GRID_SIDE_DEFAULT,
  parameter int KERNEL_RADIUS          = KERNEL_RADIUS_DEFAULT,
  parameter int POSITION_FRACTION_BITS = POS_FRAC_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  cmd_word_t             cmd_word,
  output logic                  res_valid,
  input  logic                  res_ready,
  output res_word_t             res_word,
  input  logic                  cfg_write_en,
  input  cfg_index_t            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  dgsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  dgsa_datapath #(
    .GRID_SIDE             (GRID_SIDE),
    .KERNEL_RADIUS         (KERNEL_RADIUS),
    .POSITION_FRACTION_BITS(POSITION_FRACTION_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_write_en(cfg_write_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd_word    (cmd_word),
    .ctrl        (ctrl),
    .stat        (stat),
    .res_word    (res_word)
  );

endmodule

@@ rtl/core/dgsa_ram.sv @@
`timescale 1ns / 1ps
module dgsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/dgsa_ctrl.sv @@
`timescale 1ns / 1ps
`include "density_grid_splat_accumulator_defines.svh"
module dgsa_ctrl
  import dgsa_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  output logic     cmd_ready,
  output logic     res_valid,
  input  logic     res_ready,
  input  dp_stat_t stat,
  output dp_ctrl_t ctrl
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MAP,
    S_CHECK,
    S_RUN,
    S_DRAIN,
    S_QREAD,
    S_QSQ,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign cmd_ready = (state == S_IDLE);

  always_comb begin
    ctrl       = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        ctrl.clear_step = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid) begin
          ctrl.load_in = 1'b1;
          state_next   = S_MAP;
        end
      end
      S_MAP: begin
        ctrl.map   = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        ctrl.check = 1'b1;
        case (stat.command) inside
          CMD_ADD, CMD_SUB: state_next = stat.skip ? S_DONE : S_RUN;
          CMD_QUERY:        state_next = stat.at_edge ? S_DONE : S_QREAD;
          default:          state_next = S_DONE;
        endcase
      end
      S_RUN: begin
        ctrl.step = 1'b1;
        if (stat.last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_DONE;
      end
      S_QREAD: begin
        state_next = S_QSQ;
      end
      S_QSQ: begin
        ctrl.sq_load = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (!res_valid || res_ready) begin
          ctrl.load_out = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.load_out) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  `DGSA_ASSERT_NOW(a_no_overwrite, clk, rst, ctrl.load_out, !res_valid || res_ready)
  `DGSA_ASSERT_NEXT(a_one_word_in_flight, clk, rst, cmd_valid && cmd_ready, !cmd_ready)

endmodule

@@ rtl/core/dgsa_datapath.sv @@
`timescale 1ns / 1ps
`include "density_grid_splat_accumulator_defines.svh"
module dgsa_datapath
  import dgsa_pkg::*;
#(
  parameter int GRID_SIDE              = GRID_SIDE_DEFAULT,
  parameter int KERNEL_RADIUS          = KERNEL_RADIUS_DEFAULT,
  parameter int POSITION_FRACTION_BITS = POS_FRAC_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_en,
  input  cfg_index_t            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  cmd_word_t             cmd_word,
  input  dp_ctrl_t              ctrl,
  output dp_stat_t              stat,
  output res_word_t             res_word
);

  localparam int CELL_W = $clog2(GRID_SIDE);
  localparam int DEPTH  = GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SPAN   = 2 * KERNEL_RADIUS;
  localparam int CNT_W  = $clog2(SPAN + 1);
  localparam int TENT_W = $clog2(KERNEL_RADIUS + 1);
  localparam int WGT_W  = 2 * TENT_W;
  localparam int SUM_W  = POS_W + 1;

  localparam logic [POS_W-1:0] K_LO   = POS_W'(KERNEL_RADIUS);
  localparam logic [POS_W-1:0] K_HI   = POS_W'(GRID_SIDE - 1 - KERNEL_RADIUS);
  localparam logic [POS_W-1:0] SIDE_P = POS_W'(GRID_SIDE);

  logic [OFFSET_W-1:0] origin_offset;
  logic [SHIFT_W-1:0]  cell_shift;
  logic [MARGIN_W-1:0] edge_margin;

  cmd_code_t               cmd_r;
  logic signed [POS_W-1:0] x_r;
  logic signed [POS_W-1:0] y_r;

  logic [SUM_W-1:0] sum_x;
  logic [SUM_W-1:0] sum_y;
  logic [4:0]       shamt;
  logic             neg_x;
  logic             neg_y;
  logic [POS_W-1:0] cx;
  logic [POS_W-1:0] cy;

  logic [POS_W-1:0]  margin_ext;
  logic [POS_W-1:0]  edge_hi;
  logic              skip;
  logic              at_edge;
  logic [CELL_W-1:0] row_start;
  logic [CELL_W-1:0] col_start;
  logic [ADDR_W-1:0] start_addr;

  logic [ADDR_W-1:0] addr_r;
  logic [CNT_W-1:0]  row_cnt;
  logic [CNT_W-1:0]  col_cnt;
  logic [WGT_W-1:0]  weight;

  logic              wr_valid;
  logic [ADDR_W-1:0] wr_addr;
  logic [WGT_W-1:0]  wr_weight;

  logic [CELL_DATA_W-1:0] rdata;
  logic [CELL_DATA_W:0]   add_sum;
  logic [CELL_DATA_W-1:0] wgt_ext;
  logic [CELL_DATA_W-1:0] new_val;
  logic                   clamp;
  logic                   sat_r;

  logic [ADDR_W-1:0]      clr_addr;
  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [CELL_DATA_W-1:0] ram_wdata;

  logic [DENSITY_W-1:0] sq_r;
  res_word_t            res_hold;

  function automatic logic [TENT_W-1:0] tent(input logic [CNT_W-1:0] k);
    if (k <= CNT_W'(KERNEL_RADIUS)) begin
      tent = TENT_W'(k);
    end else begin
      tent = TENT_W'(CNT_W'(SPAN) - k);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_offset <= ORIGIN_OFFSET_RESET;
      cell_shift    <= CELL_SHIFT_RESET;
      edge_margin   <= EDGE_MARGIN_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_ORIGIN_OFFSET: origin_offset <= cfg_data[OFFSET_W-1:0];
        REG_CELL_SHIFT:    cell_shift    <= cfg_data[SHIFT_W-1:0];
        REG_EDGE_MARGIN:   edge_margin   <= cfg_data[MARGIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign shamt = 5'(POSITION_FRACTION_BITS) + 5'(cell_shift);
  assign sum_x = {x_r[POS_W-1], x_r} + SUM_W'(origin_offset);
  assign sum_y = {y_r[POS_W-1], y_r} + SUM_W'(origin_offset);

  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      cmd_r <= cmd_word.command;
      x_r   <= cmd_word.x_position;
      y_r   <= cmd_word.y_position;
    end
    if (ctrl.map) begin
      neg_x <= sum_x[SUM_W-1];
      neg_y <= sum_y[SUM_W-1];
      cx    <= sum_x[POS_W-1:0] >> shamt;
      cy    <= sum_y[POS_W-1:0] >> shamt;
    end
  end

  assign margin_ext = POS_W'(edge_margin);
  assign edge_hi    = SIDE_P - margin_ext;

  assign skip = neg_x || neg_y || (cx < K_LO) || (cy < K_LO) || (cx > K_HI) || (cy > K_HI);
  assign at_edge = neg_x || neg_y || (cx < margin_ext) || (cy < margin_ext) ||
                   (cx > edge_hi) || (cy > edge_hi) || (cx >= SIDE_P) || (cy >= SIDE_P);

  always_comb begin
    if (cmd_r == CMD_QUERY) begin
      row_start = cy[CELL_W-1:0];
      col_start = cx[CELL_W-1:0];
    end else begin
      row_start = cy[CELL_W-1:0] - CELL_W'(KERNEL_RADIUS);
      col_start = cx[CELL_W-1:0] - CELL_W'(KERNEL_RADIUS);
    end
    start_addr = ADDR_W'(row_start) * ADDR_W'(GRID_SIDE) + ADDR_W'(col_start);
  end

  // The kernel walk runs row by row over the (2R+1)x(2R+1) window.
  always_ff @(posedge clk) begin
    if (ctrl.check) begin
      addr_r  <= start_addr;
      row_cnt <= '0;
      col_cnt <= '0;
    end else if (ctrl.step) begin
      if (col_cnt == CNT_W'(SPAN)) begin
        col_cnt <= '0;
        row_cnt <= row_cnt + CNT_W'(1);
        addr_r  <= addr_r + ADDR_W'(GRID_SIDE - SPAN);
      end else begin
        col_cnt <= col_cnt + CNT_W'(1);
        addr_r  <= addr_r + ADDR_W'(1);
      end
    end
  end

  assign weight = WGT_W'(tent(row_cnt)) * WGT_W'(tent(col_cnt));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_valid <= 1'b0;
    end else begin
      wr_valid <= ctrl.step;
    end
    wr_addr   <= addr_r;
    wr_weight <= weight;
  end

  always_comb begin
    wgt_ext = CELL_DATA_W'(wr_weight);
    add_sum = {1'b0, rdata} + {1'b0, wgt_ext};
    clamp   = 1'b0;
    if (cmd_r == CMD_SUB) begin
      if (rdata < wgt_ext) begin
        new_val = '0;
        clamp   = 1'b1;
      end else begin
        new_val = rdata - wgt_ext;
      end
    end else begin
      if (add_sum[CELL_DATA_W]) begin
        new_val = '1;
        clamp   = 1'b1;
      end else begin
        new_val = add_sum[CELL_DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sat_r    <= 1'b0;
      clr_addr <= '0;
    end else begin
      if (ctrl.load_in) begin
        sat_r <= 1'b0;
      end else if (wr_valid && clamp) begin
        sat_r <= 1'b1;
      end
      if (ctrl.clear_step) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
    end
  end

  assign ram_we    = ctrl.clear_step || wr_valid;
  assign ram_waddr = ctrl.clear_step ? clr_addr : wr_addr;
  assign ram_wdata = ctrl.clear_step ? '0 : new_val;

  dgsa_ram #(
    .WIDTH(CELL_DATA_W),
    .DEPTH(DEPTH)
  ) u_cells (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(addr_r),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (ctrl.sq_load) begin
      sq_r <= DENSITY_W'(rdata) * DENSITY_W'(rdata);
    end
    if (ctrl.load_out) begin
      case (cmd_r) inside
        CMD_ADD, CMD_SUB: begin
          res_hold.density_squared <= '0;
          res_hold.status          <= skip ? ST_SKIP : (sat_r ? ST_SAT : ST_OK);
        end
        CMD_QUERY: begin
          res_hold.density_squared <= at_edge ? '1 : sq_r;
          res_hold.status          <= at_edge ? ST_EDGE : ST_OK;
        end
        default: begin
          res_hold.density_squared <= '0;
          res_hold.status          <= ST_OK;
        end
      endcase
    end
  end

  assign res_word = res_hold;

  assign stat.command    = cmd_r;
  assign stat.clear_last = (clr_addr == ADDR_W'(DEPTH - 1));
  assign stat.skip       = skip;
  assign stat.at_edge    = at_edge;
  assign stat.last       = (row_cnt == CNT_W'(SPAN)) && (col_cnt == CNT_W'(SPAN));

  `DGSA_ASSERT_NOW(a_write_not_during_clear, clk, rst, wr_valid, !ctrl.clear_step)
  `DGSA_ASSERT_NOW(a_sat_only_update, clk, rst, sat_r, cmd_r == CMD_ADD || cmd_r == CMD_SUB)
  `DGSA_ASSERT_NEXT(a_step_writes_back, clk, rst, ctrl.step, wr_valid)

endmodule
